[design/bmf_pkg.sv]
// Package for the raster box mean filter.
// Holds field widths, config register indexes, command codes and parameter defaults.
// No dependencies.
`default_nettype none
package bmf_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HALF_X_DEF = 8;
  localparam int MAX_HALF_Y_DEF = 8;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 3;
  localparam int FW_W    = 11;
  localparam int FH_W    = 13;
  localparam int HALF_W  = 4;
  localparam int COV_W   = 13;

  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] CFG_HALF_X       = 3'd2;
  localparam logic [IDX_W-1:0] CFG_HALF_Y       = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ROW_COVERAGE = 3'd4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;
endpackage
`default_nettype wire

[design/box_mean_filter_raster.sv]
// Raster box mean filter, top level. Uses bmf_pkg, bmf_ring_mem and bmf_div.
// Each pixel request is stored in a ring of (2*MAX_HALF_Y+1)*MAX_WIDTH bytes and leaves
// half_window_y rows plus half_window_x pixels later; a flush request drains one delayed pixel.
// An averaged pixel is paced by the single ring read port (one window byte per cycle)
// and the bit-serial divider (one quotient bit per cycle). Requests are taken only once
// the previous result is in the output register, also while that result still waits.
// Config changes settle through the derived config registers after a write and after
// reset; requests are held off until then.
`default_nettype none
module box_mean_filter_raster #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF_X = bmf_pkg::MAX_HALF_X_DEF,
  parameter int MAX_HALF_Y = bmf_pkg::MAX_HALF_Y_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_cmd,
  input  wire logic [bmf_pkg::PIX_W-1:0]  in_pixel_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [bmf_pkg::PIX_W-1:0]  out_pixel_out,
  output logic                            out_frame_last,
  input  wire logic                       cfg_we,
  input  wire logic [bmf_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [bmf_pkg::CFG_W-1:0]  cfg_data
);
  localparam int DEPTH  = (2 * MAX_HALF_Y + 1) * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PEND_W = $clog2(DEPTH + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEF_W  = $clog2(MAX_WIDTH + 1);
  localparam int HX_W   = $clog2(MAX_HALF_X + 1);
  localparam int HY_W   = $clog2(MAX_HALF_Y + 1);
  localparam int SPX_W  = $clog2(2 * MAX_HALF_X + 1);
  localparam int SPY_W  = $clog2(2 * MAX_HALF_Y + 1);
  localparam int NMAX   = (2 * MAX_HALF_X + 1) * (2 * MAX_HALF_Y + 1);
  localparam int N_W    = $clog2(NMAX + 1);
  localparam int SUM_W  = $clog2(NMAX * 255 + NMAX / 2 + 1);
  localparam int PROD_W = HY_W + WEF_W;
  localparam int DLY_W  = PROD_W + 1;
  localparam int ROW_W  = bmf_pkg::FH_W;

  localparam logic [1:0] CFG_SETTLE = 2'd3;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOC   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // config registers
  logic [bmf_pkg::FW_W-1:0]   fw_r;
  logic [bmf_pkg::FH_W-1:0]   fh_r;
  logic [bmf_pkg::HALF_W-1:0] hx_cfg_r, hy_cfg_r;
  logic [bmf_pkg::COV_W-1:0]  cov_r;
  logic [1:0]                 settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= bmf_pkg::FW_W'(1024);
      fh_r     <= bmf_pkg::FH_W'(1024);
      hx_cfg_r <= bmf_pkg::HALF_W'(1);
      hy_cfg_r <= bmf_pkg::HALF_W'(1);
      cov_r    <= bmf_pkg::COV_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmf_pkg::CFG_FRAME_WIDTH:  fw_r     <= cfg_data[bmf_pkg::FW_W-1:0];
        bmf_pkg::CFG_FRAME_HEIGHT: fh_r     <= cfg_data[bmf_pkg::FH_W-1:0];
        bmf_pkg::CFG_HALF_X:       hx_cfg_r <= cfg_data[bmf_pkg::HALF_W-1:0];
        bmf_pkg::CFG_HALF_Y:       hy_cfg_r <= cfg_data[bmf_pkg::HALF_W-1:0];
        bmf_pkg::CFG_ROW_COVERAGE: cov_r    <= cfg_data[bmf_pkg::COV_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off requests until the derived config has caught up
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      settle_r <= CFG_SETTLE;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // derived config, three register stages
  logic [WEF_W-1:0]  w_r;
  logic [ROW_W-1:0]  h_r;
  logic [HX_W-1:0]   hx_r;
  logic [HY_W-1:0]   hy_r;
  logic [PROD_W-1:0] prod_r;
  logic [N_W-1:0]    n_r;
  logic              fits_r;
  logic [PEND_W-1:0] dly_r;
  logic [ADDR_W-1:0] back_r;
  logic [DLY_W-1:0]  dly_sum;

  always_ff @(posedge clk) begin
    if (fw_r == '0) begin
      w_r <= WEF_W'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_r <= WEF_W'(MAX_WIDTH);
    end else begin
      w_r <= WEF_W'(fw_r);
    end
    h_r  <= (fh_r == '0) ? ROW_W'(1) : fh_r;
    hx_r <= (32'(hx_cfg_r) > MAX_HALF_X) ? HX_W'(MAX_HALF_X) : HX_W'(hx_cfg_r);
    hy_r <= (32'(hy_cfg_r) > MAX_HALF_Y) ? HY_W'(MAX_HALF_Y) : HY_W'(hy_cfg_r);
    prod_r <= PROD_W'(hy_r * w_r);
    n_r    <= N_W'((32'(hx_r) * 2 + 1) * (32'(hy_r) * 2 + 1));
    fits_r <= (32'(w_r) >= 32'(hx_r) * 2 + 1) && (32'(h_r) >= 32'(hy_r) * 2 + 1);
    dly_r  <= (32'(dly_sum) > DEPTH - 1) ? PEND_W'(DEPTH - 1) : PEND_W'(dly_sum);
    back_r <= (32'(dly_sum) >= DEPTH) ? ADDR_W'(32'(dly_sum) - DEPTH) : ADDR_W'(dly_sum);
  end

  assign dly_sum = DLY_W'(prod_r) + DLY_W'(hx_r);

  // datapath and sequencer
  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               avg_r, avg_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [SPX_W-1:0]   cx_r, cx_nxt, spx_r, spx_nxt;
  logic [SPY_W-1:0]   cy_r, cy_nxt, spy_r, spy_nxt;
  logic               issued_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt, total;
  logic [bmf_pkg::PIX_W-1:0] res_r, res_nxt;
  logic               ov_r, ov_nxt;
  logic [bmf_pkg::PIX_W-1:0] opix_r, opix_nxt;
  logic               olast_r, olast_nxt;
  logic               we;
  logic [bmf_pkg::PIX_W-1:0] rd_data;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   quo;
  logic [31:0]        tmp, nb;
  logic               last_row;

  bmf_ring_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(bmf_pkg::PIX_W)) u_ring (
    .clk(clk), .we(we), .waddr(wr_addr_r), .wdata(in_pixel_in),
    .raddr(rd_addr_r), .rdata(rd_data)
  );

  bmf_div #(.NUM_W(SUM_W), .DEN_W(N_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(SUM_W'(total + SUM_W'(n_r >> 1))), .den(n_r),
    .done(div_done), .quo(quo)
  );

  assign in_ready = (state_r == S_IDLE) && (settle_r == '0);
  assign total    = sum_r + SUM_W'(rd_data);

  always_comb begin
    state_nxt   = state_r;
    wr_addr_nxt = wr_addr_r;
    pend_nxt    = pend_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    addr_nxt    = addr_r;
    avg_nxt     = avg_r;
    rd_addr_nxt = rd_addr_r;
    base_nxt    = base_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    spx_nxt     = spx_r;
    spy_nxt     = spy_r;
    sum_nxt     = sum_r;
    res_nxt     = res_r;
    ov_nxt      = ov_r && !out_ready;
    opix_nxt    = opix_r;
    olast_nxt   = olast_r;
    we          = 1'b0;
    div_start   = 1'b0;
    tmp         = '0;
    nb          = '0;
    last_row    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_cmd == bmf_pkg::CMD_PIXEL) begin
            we          = 1'b1;
            wr_addr_nxt = (32'(wr_addr_r) == DEPTH - 1) ? '0 : wr_addr_r + 1'b1;
            pend_nxt    = pend_r + 1'b1;
            if ((pend_r + 1'b1) > dly_r) begin
              state_nxt = S_LOC;
            end
          end else if (pend_r != '0) begin
            state_nxt = S_LOC;
          end
        end
      end
      S_LOC: begin
        tmp = 32'(wr_addr_r) - 32'(pend_r);
        if (32'(wr_addr_r) < 32'(pend_r)) begin
          tmp = tmp + DEPTH;
        end
        addr_nxt = ADDR_W'(tmp);
        avg_nxt  = fits_r && (32'(col_r) >= 32'(hx_r)) &&
                   (32'(col_r) + 32'(hx_r) < 32'(w_r)) &&
                   (32'(row_r) >= 32'(hy_r)) &&
                   (32'(row_r) + 32'(hy_r) < 32'(h_r)) &&
                   ((32'(row_r) == 32'(hy_r)) || (row_r < cov_r));
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        if (avg_r) begin
          tmp = 32'(addr_r) - 32'(back_r);
          if (addr_r < back_r) begin
            tmp = tmp + DEPTH;
          end
          spx_nxt = SPX_W'(32'(hx_r) * 2);
          spy_nxt = SPY_W'(32'(hy_r) * 2);
        end else begin
          tmp     = 32'(addr_r);
          spx_nxt = '0;
          spy_nxt = '0;
        end
        rd_addr_nxt = ADDR_W'(tmp);
        base_nxt    = ADDR_W'(tmp);
        cx_nxt      = '0;
        cy_nxt      = '0;
        sum_nxt     = '0;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        if (issued_r) begin
          sum_nxt = total;
        end
        if (cx_r == spx_r) begin
          nb = 32'(base_r) + 32'(w_r);
          if (nb >= DEPTH) begin
            nb = nb - DEPTH;
          end
          cx_nxt      = '0;
          base_nxt    = ADDR_W'(nb);
          rd_addr_nxt = ADDR_W'(nb);
          if (cy_r == spy_r) begin
            state_nxt = S_LAST;
          end else begin
            cy_nxt = cy_r + 1'b1;
          end
        end else begin
          cx_nxt      = cx_r + 1'b1;
          rd_addr_nxt = (32'(rd_addr_r) == DEPTH - 1) ? '0 : rd_addr_r + 1'b1;
        end
      end
      S_LAST: begin
        if (avg_r) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          res_nxt   = total[bmf_pkg::PIX_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = quo[bmf_pkg::PIX_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          last_row = (32'(row_r) + 1 >= 32'(h_r));
          ov_nxt   = 1'b1;
          opix_nxt = res_r;
          if (32'(col_r) + 1 >= 32'(w_r)) begin
            olast_nxt = last_row;
            col_nxt   = '0;
            row_nxt   = last_row ? '0 : row_r + 1'b1;
          end else begin
            olast_nxt = 1'b0;
            col_nxt   = col_r + 1'b1;
          end
          pend_nxt  = pend_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wr_addr_r <= '0;
      pend_r    <= '0;
      row_r     <= '0;
      col_r     <= '0;
      ov_r      <= 1'b0;
      issued_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_addr_r <= wr_addr_nxt;
      pend_r    <= pend_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      ov_r      <= ov_nxt;
      issued_r  <= (state_r == S_SUM);
    end
    addr_r    <= addr_nxt;
    avg_r     <= avg_nxt;
    rd_addr_r <= rd_addr_nxt;
    base_r    <= base_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    spx_r     <= spx_nxt;
    spy_r     <= spy_nxt;
    sum_r     <= sum_nxt;
    res_r     <= res_nxt;
    opix_r    <= opix_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_pixel_out  = opix_r;
  assign out_frame_last = olast_r;
endmodule
`default_nettype wire

[design/bmf_ring_mem.sv]
// Ring store of delayed pixels: one write port, one read port.
// Read data is registered. No dependencies.
`default_nettype none
module bmf_ring_mem #(
  parameter int DEPTH  = 17408,
  parameter int ADDR_W = 15,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/bmf_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used for the rounded window mean. No dependencies.
`default_nettype none
module bmf_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[NUM_W-1]};
    if (start) begin
      cnt_nxt = CNT_W'(NUM_W);
      rem_nxt = '0;
      q_nxt   = num;
    end else if (cnt_r != '0) begin
      if (rem_sh >= {1'b0, den}) begin
        rem_nxt = DEN_W'(rem_sh - {1'b0, den});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

[design/bmf_checker.sv]
// Port-level checks for box_mean_filter_raster, bound to the top level.
// Depends on bmf_pkg for widths.
`default_nettype none
module bmf_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [bmf_pkg::PIX_W-1:0] out_pixel_out,
  input wire logic                      out_frame_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) && $stable(out_frame_last))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while taking requests");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !$rose(out_valid))
    else $error("result appeared right after a request");
endmodule

bind box_mean_filter_raster bmf_checker u_bmf_checker (.*);
`default_nettype wire
